[hw/rtl/nch_pkg.sv]
// shared types and constants of the nearest centroid histogram block
// used by nearest_centroid_histogram; depends on nothing
package nch_pkg;

   // field widths of the item and configuration ports
   localparam int KindW   = 1;
   localparam int TopicW  = 5;
   localparam int CompW   = 6;
   localparam int ValueW  = 16;
   localparam int CsrW    = 6;

   // datapath widths
   localparam int ProdW   = 32;
   localparam int AccW    = 38;
   localparam int CountW  = 32;

   // item kinds
   localparam logic [KindW-1:0] KindWrite = 1'b0;
   localparam logic [KindW-1:0] KindQuery = 1'b1;

   // topics_in_use after reset
   localparam logic [CsrW-1:0] TopicsInUseRst = 6'd32;

   // saturation bounds of a Q8.30 accumulator
   localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
   localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PASS,
      ST_DRAIN,
      ST_CNT_RD,
      ST_EMIT
   } state_type;

endpackage

[hw/rtl/nch_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module nch_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[hw/rtl/nearest_centroid_histogram.sv]
// A centre write item is accepted in idle and written to the centre memory. A query item
// walks all TOPICS, one topic a cycle through the shared 16x16 multiplier and accumulator
// memory port, then drains the pipeline. An item with last set then reads the hit counter
// and emits the result, which waits on rsp_stall. One item is worked on at a time.
// Reset: accumulators and hit counters read as zero through per-topic valid bits,
// topics_in_use returns to 32; the centre memory keeps its contents, no clearing pass.
// depends on nch_pkg and nch_ram
module nearest_centroid_histogram #(
   parameter int DIMENSIONS = 64,
   parameter int TOPICS     = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input item channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [nch_pkg::KindW-1:0]            req_kind,
   input  logic [nch_pkg::TopicW-1:0]           req_topic_index,
   input  logic [nch_pkg::CompW-1:0]            req_component,
   input  logic signed [nch_pkg::ValueW-1:0]    req_value,
   input  logic                                 req_last,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [nch_pkg::TopicW-1:0]           rsp_nearest,
   output logic [nch_pkg::CountW-1:0]           rsp_hit_count,
   output logic signed [nch_pkg::AccW-1:0]      rsp_best_score,
   // configuration
   input  logic                                 csr_wr_en,
   input  logic [nch_pkg::CsrW-1:0]             csr_wr_data
);

   localparam int TW = $clog2(TOPICS);
   localparam int DW = $clog2(DIMENSIONS);
   localparam int AW = TW + DW;
   localparam logic [TW-1:0] TopicLast = TW'(TOPICS - 1);
   localparam logic [TW:0]   TopicsMax = (TW+1)'(TOPICS);

   // ---------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------
   nch_pkg::state_type state_ff, state_in;

   logic [nch_pkg::CsrW-1:0]          topics_in_use_ff;
   logic [TW-1:0]                     t_ff, t_in;
   logic                              s1_vld_ff, s1_vld_in;
   logic [TW-1:0]                     s1_t_ff;
   logic                              s2_vld_ff;
   logic [TW-1:0]                     s2_t_ff;
   logic [TOPICS-1:0]                 acc_vld_ff, acc_vld_in;
   logic [TOPICS-1:0]                 cnt_vld_ff, cnt_vld_in;

   logic signed [nch_pkg::ValueW-1:0] value_ff;
   logic [DW-1:0]                     comp_ff;
   logic                              comp_ok_ff;
   logic                              last_ff;
   logic signed [nch_pkg::ProdW-1:0]  prod_ff, prod_in;
   logic signed [nch_pkg::AccW-1:0]   acc_old_ff, acc_old_in;
   logic [TW-1:0]                     best_ff;
   logic signed [nch_pkg::AccW-1:0]   best_score_ff;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [nch_pkg::TopicW-1:0]        rsp_nearest_ff;
   logic [nch_pkg::CountW-1:0]        rsp_hit_count_ff;
   logic signed [nch_pkg::AccW-1:0]   rsp_best_score_ff;

   // ---------------------------------------------------------------
   // input decode
   // ---------------------------------------------------------------
   logic        req_fire;
   logic [31:0] topic_ext;
   logic [31:0] comp_ext;
   logic        wr_fire;
   logic        query_fire;

   assign req_fire   = req_valid && !req_stall;
   assign topic_ext  = 32'(req_topic_index);
   assign comp_ext   = 32'(req_component);
   assign wr_fire    = req_fire && (req_kind == nch_pkg::KindWrite)
                       && (topic_ext < TOPICS) && (comp_ext < DIMENSIONS);
   assign query_fire = req_fire && (req_kind == nch_pkg::KindQuery);

   // clamp topics_in_use into 1..TOPICS
   logic [31:0] csr_ext;
   logic [TW:0] n_lim;

   assign csr_ext = 32'(topics_in_use_ff);

   always_comb begin
      if (csr_ext == 32'd0) begin
         n_lim = (TW+1)'(1);
      end else if (csr_ext > TOPICS) begin
         n_lim = TopicsMax;
      end else begin
         n_lim = csr_ext[TW:0];
      end
   end

   // ---------------------------------------------------------------
   // memories
   // ---------------------------------------------------------------
   logic [AW-1:0]                    ctr_wr_addr;
   logic [AW-1:0]                    ctr_rd_addr;
   logic [nch_pkg::ValueW-1:0]       ctr_rd_data;
   logic                             acc_wr_en;
   logic signed [nch_pkg::AccW-1:0]  acc_sat;
   logic [nch_pkg::AccW-1:0]         acc_rd_data;
   logic                             cnt_wr_en;
   logic [nch_pkg::CountW-1:0]       cnt_new;
   logic [nch_pkg::CountW-1:0]       cnt_rd_data;

   assign ctr_wr_addr = {topic_ext[TW-1:0], comp_ext[DW-1:0]};
   assign ctr_rd_addr = {t_ff, comp_ff};

   nch_ram #(
      .WIDTH (nch_pkg::ValueW),
      .DEPTH (1 << AW)
   ) u_centre_ram (
      .clock   (clock),
      .wr_en   (wr_fire),
      .wr_addr (ctr_wr_addr),
      .wr_data (req_value),
      .rd_addr (ctr_rd_addr),
      .rd_data (ctr_rd_data)
   );

   nch_ram #(
      .WIDTH (nch_pkg::AccW),
      .DEPTH (TOPICS)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_wr_en),
      .wr_addr (s2_t_ff),
      .wr_data (acc_sat),
      .rd_addr (t_ff),
      .rd_data (acc_rd_data)
   );

   nch_ram #(
      .WIDTH (nch_pkg::CountW),
      .DEPTH (TOPICS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (best_ff),
      .wr_data (cnt_new),
      .rd_addr (best_ff),
      .rd_data (cnt_rd_data)
   );

   // ---------------------------------------------------------------
   // stage 1: multiply centre component by query component
   // ---------------------------------------------------------------
   logic signed [nch_pkg::ValueW-1:0] ctr_val;
   logic signed [nch_pkg::ProdW-1:0]  prod_full;

   assign ctr_val    = ctr_rd_data;
   assign prod_full  = nch_pkg::ProdW'(ctr_val) * nch_pkg::ProdW'(value_ff);
   assign prod_in    = comp_ok_ff ? prod_full : '0;
   assign acc_old_in = acc_vld_ff[s1_t_ff] ? acc_rd_data : '0;

   // ---------------------------------------------------------------
   // stage 2: saturating accumulate, running maximum
   // ---------------------------------------------------------------
   logic signed [nch_pkg::AccW:0] acc_sum;
   logic                          in_search;
   logic                          best_upd;

   assign acc_sum   = (nch_pkg::AccW+1)'(acc_old_ff) + (nch_pkg::AccW+1)'(prod_ff);
   assign acc_sat   = (acc_sum[nch_pkg::AccW] != acc_sum[nch_pkg::AccW-1])
                      ? (acc_sum[nch_pkg::AccW] ? nch_pkg::AccMin : nch_pkg::AccMax)
                      : acc_sum[nch_pkg::AccW-1:0];
   assign acc_wr_en = s2_vld_ff;
   assign in_search = last_ff && s2_vld_ff && ({1'b0, s2_t_ff} < n_lim);
   // first topic seeds the search, later ones win only when strictly greater
   assign best_upd  = in_search && ((s2_t_ff == '0) || (acc_sat > best_score_ff));

   // ---------------------------------------------------------------
   // hit counter update
   // ---------------------------------------------------------------
   logic [nch_pkg::CountW-1:0] cnt_cur;
   logic                       rsp_free;
   logic                       emit_fire;
   logic [31:0]                best_ext;

   assign cnt_cur   = cnt_vld_ff[best_ff] ? cnt_rd_data : '0;
   assign cnt_new   = (cnt_cur == '1) ? cnt_cur : cnt_cur + 1'b1;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_fire = (state_ff == nch_pkg::ST_EMIT) && rsp_free;
   assign cnt_wr_en = emit_fire;
   assign best_ext  = 32'(best_ff);

   // ---------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------
   always_comb begin
      state_in   = state_ff;
      t_in       = t_ff;
      s1_vld_in  = 1'b0;
      acc_vld_in = acc_vld_ff;
      cnt_vld_in = cnt_vld_ff;
      req_stall  = 1'b1;

      if (acc_wr_en) begin
         acc_vld_in[s2_t_ff] = 1'b1;
      end

      case (state_ff)
         nch_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            t_in      = '0;
            if (query_fire) begin
               state_in = nch_pkg::ST_PASS;
            end
         end
         nch_pkg::ST_PASS: begin
            s1_vld_in = 1'b1;
            t_in      = t_ff + 1'b1;
            if (t_ff == TopicLast) begin
               state_in = nch_pkg::ST_DRAIN;
            end
         end
         nch_pkg::ST_DRAIN: begin
            if (!s1_vld_ff) begin
               state_in = last_ff ? nch_pkg::ST_CNT_RD : nch_pkg::ST_IDLE;
            end
         end
         nch_pkg::ST_CNT_RD: begin
            state_in = nch_pkg::ST_EMIT;
         end
         nch_pkg::ST_EMIT: begin
            if (rsp_free) begin
               state_in            = nch_pkg::ST_IDLE;
               acc_vld_in          = '0;
               cnt_vld_in[best_ff] = 1'b1;
            end
         end
         default: begin
            state_in = nch_pkg::ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= nch_pkg::ST_IDLE;
         topics_in_use_ff <= nch_pkg::TopicsInUseRst;
         t_ff             <= '0;
         s1_vld_ff        <= 1'b0;
         s2_vld_ff        <= 1'b0;
         acc_vld_ff       <= '0;
         cnt_vld_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         t_ff       <= t_in;
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s1_vld_ff;
         acc_vld_ff <= acc_vld_in;
         cnt_vld_ff <= cnt_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            topics_in_use_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (query_fire) begin
         value_ff   <= req_value;
         comp_ff    <= comp_ext[DW-1:0];
         comp_ok_ff <= comp_ext < DIMENSIONS;
         last_ff    <= req_last;
      end
      s1_t_ff    <= t_ff;
      s2_t_ff    <= s1_t_ff;
      prod_ff    <= prod_in;
      acc_old_ff <= acc_old_in;
      if (best_upd) begin
         best_ff       <= s2_t_ff;
         best_score_ff <= acc_sat;
      end
      if (emit_fire) begin
         rsp_nearest_ff    <= best_ext[nch_pkg::TopicW-1:0];
         rsp_hit_count_ff  <= cnt_new;
         rsp_best_score_ff <= best_score_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_nearest    = rsp_nearest_ff;
   assign rsp_hit_count  = rsp_hit_count_ff;
   assign rsp_best_score = rsp_best_score_ff;

endmodule
